>>> rtl/core/cnbs_pkg.sv
// Shared types, constants and fixed-point helpers for the cubic Newton bond solver.
// No dependencies.
`timescale 1ns / 1ps
package cnbs_pkg;
	localparam int MaxIterations = 20;
	localparam int FractionBits = 16;
	localparam int ValW = 40;             // sign + 39-bit magnitude
	localparam int MagW = 39;
	localparam logic [MagW-1:0] FxLim = {MagW{1'b1}};
	localparam logic [16:0] TolInv = 17'd100000;

	typedef enum logic [1:0] {
		ST_CONVERGED = 2'd0,
		ST_ITER_LIMIT = 2'd1,
		ST_ZERO_LIGAND = 2'd2,
		ST_ZERO_DERIV = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_RECEPTOR = 2'd0,
		REG_INV_RATE_ONE = 2'd1,
		REG_RATE_TWO = 2'd2,
		REG_RATE_THREE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] ligand_level;
		logic [31:0] antibody_level;
	} in_word_t;

	typedef struct packed {
		logic [31:0] bond_level;
		logic [4:0] iterations_used;
		logic [1:0] solve_status;
	} out_word_t;

	typedef struct packed {
		logic [1:0] index;
		logic [31:0] data;
	} cfg_word_t;

	// datapath micro-operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL,
		OP_DIV,
		OP_ADD,
		OP_SUB
	} alu_op_t;

	typedef enum logic [4:0] {
		CS_IDLE, CS_AR2, CS_R3X2, CS_R3M1, CS_NUM0, CS_T2X2, CS_NUM1, CS_NUM2,
		CS_NUM3, CS_CB, CS_C0, CS_C1, CS_C2, CS_C3, CS_CC, CS_CD,
		CS_F0, CS_F1, CS_F2, CS_F3, CS_F4, CS_D0, CS_D1, CS_D2, CS_D3,
		CS_D4, CS_Q, CS_XN, CS_CHK, CS_BOND, CS_DONE
	} ctl_state_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
		logic [3:0] src_a;
		logic [3:0] src_b;
		logic [3:0] dst;
		logic neg_b;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic fd_zero;
		logic stop;
	} dp_stat_t;

	// register file slots
	localparam logic [3:0] R_T2 = 4'd0, R_AB = 4'd1, R_T1 = 4'd2, R_I1 = 4'd3,
		R_R2 = 4'd4, R_R3 = 4'd5, R_AR2 = 4'd6, R_TMP = 4'd7, R_CB = 4'd8,
		R_CC = 4'd9, R_CD = 4'd10, R_X = 4'd11, R_F = 4'd12, R_FD = 4'd13,
		R_ONE = 4'd14, R_ZERO = 4'd15;

	function automatic logic [ValW-1:0] sat_add(input logic [ValW-1:0] a,
		input logic [ValW-1:0] b);
		logic signed [ValW:0] s;
		s = $signed({a[ValW-1], a}) + $signed({b[ValW-1], b});
		if (s > $signed({2'b00, FxLim})) return {1'b0, FxLim};
		if (s < -$signed({2'b00, FxLim})) return -{1'b0, FxLim};
		return s[ValW-1:0];
	endfunction
endpackage

>>> rtl/core/cnbs_datapath.sv
// Datapath: register file, saturating adder, sequential multiplier and divider.
// Depends on cnbs_pkg.
`timescale 1ns / 1ps
module cnbs_datapath #(
	parameter int FRACTION_BITS = cnbs_pkg::FractionBits
) (
	input logic clk,
	input logic arst_n,
	input cnbs_pkg::in_word_t in_word,
	input logic load_in,
	input logic [31:0] t1,
	input logic [31:0] i1,
	input logic [31:0] r2,
	input logic [31:0] r3,
	input cnbs_pkg::dp_cmd_t cmd,
	output cnbs_pkg::dp_stat_t stat,
	output logic [31:0] bond
);
	localparam int VW = cnbs_pkg::ValW;
	localparam int MW = cnbs_pkg::MagW;
	localparam int PW = 2 * MW;
	localparam int DW = MW + FRACTION_BITS;
	localparam logic [VW-1:0] One = VW'(1) << FRACTION_BITS;

	logic [VW-1:0] rf_q [14];
	logic [VW-1:0] a, b, bb, res;
	logic [MW-1:0] ma, mb;
	logic sg_q;
	cnbs_pkg::alu_op_t op_q;
	logic [3:0] dst_q;
	logic [6:0] cnt_q;
	logic [PW-1:0] acc_q;
	logic [MW-1:0] mc_q, mbd_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] quo_q;
	logic run_q, fin;
	logic [VW-1:0] rd_result;
	logic [PW-1:0] prod_sh;
	logic [DW:0] rem_try;

	function automatic logic [VW-1:0] rd(input logic [3:0] i,
		input logic [VW-1:0] r [14]);
		if (i == cnbs_pkg::R_ONE) return One;
		if (i == cnbs_pkg::R_ZERO) return '0;
		return r[i];
	endfunction

	assign a = rd(cmd.src_a, rf_q);
	assign bb = rd(cmd.src_b, rf_q);
	assign b = cmd.neg_b ? -bb : bb;
	assign ma = a[VW-1] ? MW'(-a) : a[MW-1:0];
	assign mb = b[VW-1] ? MW'(-b) : b[MW-1:0];
	assign res = cnbs_pkg::sat_add(a, b);

	// shift-add multiply, restoring divide, one bit a cycle
	assign rem_try = {rem_q[DW-1:0], quo_q[DW-1]} - {1'b0, {(DW-MW){1'b0}}, mbd_q};
	assign prod_sh = acc_q >> FRACTION_BITS;

	always_comb begin
		logic [MW-1:0] m;
		logic ovf;
		m = '0;
		ovf = 1'b0;
		if (op_q == cnbs_pkg::OP_MUL) begin
			ovf = |prod_sh[PW-1:MW];
			m = prod_sh[MW-1:0];
		end else begin
			ovf = |quo_q[DW-1:MW];
			m = quo_q[MW-1:0];
		end
		if (ovf) m = cnbs_pkg::FxLim;
		rd_result = sg_q ? -{1'b0, m} : {1'b0, m};
	end

	// the last count writes the finished word back
	assign fin = run_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			op_q <= cnbs_pkg::OP_NONE;
		end else if (run_q) begin
			if (cnt_q == '0) run_q <= 1'b0;
			else cnt_q <= cnt_q - 7'd1;
		end else if (cmd.start && (cmd.op == cnbs_pkg::OP_MUL
				|| cmd.op == cnbs_pkg::OP_DIV)) begin
			run_q <= 1'b1;
			op_q <= cmd.op;
			cnt_q <= (cmd.op == cnbs_pkg::OP_MUL) ? 7'(MW) : 7'(DW);
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			rf_q[cnbs_pkg::R_T2] <= {8'd0, in_word.ligand_level};
			rf_q[cnbs_pkg::R_AB] <= {8'd0, in_word.antibody_level};
			rf_q[cnbs_pkg::R_T1] <= {8'd0, t1};
			rf_q[cnbs_pkg::R_I1] <= {8'd0, i1};
			rf_q[cnbs_pkg::R_R2] <= {8'd0, r2};
			rf_q[cnbs_pkg::R_R3] <= {8'd0, r3};
			rf_q[cnbs_pkg::R_X] <= '0;
		end else if (run_q) begin
			if (fin) rf_q[dst_q] <= rd_result;
			else if (op_q == cnbs_pkg::OP_MUL) begin
				// add multiplicand for each multiplier bit, MSB first
				acc_q <= (acc_q << 1) + (mbd_q[MW-1] ? {{MW{1'b0}}, mc_q} : '0);
				mbd_q <= mbd_q << 1;
			end else begin
				if (!rem_try[DW]) begin
					rem_q <= rem_try;
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DW-1:0], quo_q[DW-1]};
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end
		end else if (cmd.start) begin
			dst_q <= cmd.dst;
			sg_q <= a[VW-1] ^ b[VW-1];
			case (cmd.op)
				cnbs_pkg::OP_MUL: begin
					acc_q <= '0;
					mc_q <= ma;
					mbd_q <= mb;
				end
				cnbs_pkg::OP_DIV: begin
					rem_q <= '0;
					quo_q <= {ma, {FRACTION_BITS{1'b0}}};
					mbd_q <= mb;
				end
				cnbs_pkg::OP_ADD, cnbs_pkg::OP_SUB: rf_q[cmd.dst] <= res;
				default: ;
			endcase
		end
	end

	// restoring divide needs remainder and dividend shifting together; quotient
	// bits enter at the bottom while dividend bits leave the top of quo_q.

	// Newton stop test on xn (R_F holds xn) against x
	logic [VW-1:0] xn, x, dl;
	logic [MW-1:0] dm;
	logic [MW+17-1:0] dprod;
	assign xn = rf_q[cnbs_pkg::R_F];
	assign x = rf_q[cnbs_pkg::R_X];
	assign dl = xn - x;
	assign dm = dl[VW-1] ? MW'(-dl) : dl[MW-1:0];
	assign dprod = dm * cnbs_pkg::TolInv;
	assign stat.busy = run_q;
	assign stat.fd_zero = (rf_q[cnbs_pkg::R_FD] == '0);
	assign stat.stop = xn[VW-1] || (dprod <= {17'd0, xn[MW-1:0]});

	// bond = T2 * x, held in R_TMP by the controller
	logic [VW-1:0] bv;
	assign bv = rf_q[cnbs_pkg::R_TMP];
	assign bond = (bv[VW-1] || bv == '0) ? 32'd0 :
		(|bv[MW-1:32] ? 32'hFFFF_FFFF : bv[31:0]);

	ast_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> cnt_q <= 7'(DW)) else $error("counter out of range");
	ast_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !run_q) else $error("unit still busy after finish");
	ast_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !fin |=> run_q) else $error("unit dropped early");
endmodule

>>> rtl/core/cnbs_control.sv
// Controller: sequences setup, Newton steps and the result word.
// Depends on cnbs_pkg.
`timescale 1ns / 1ps
module cnbs_control #(
	parameter int MAX_ITERATIONS = cnbs_pkg::MaxIterations
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic zero_lig,
	input cnbs_pkg::dp_stat_t stat,
	output cnbs_pkg::dp_cmd_t cmd,
	output logic load_in,
	output logic busy,
	output logic done,
	output logic [4:0] steps,
	output cnbs_pkg::status_t status
);
	localparam int SW = $clog2(MAX_ITERATIONS + 1);
	cnbs_pkg::ctl_state_t st_q, st_d;
	logic issued_q;
	logic [SW-1:0] steps_q;
	cnbs_pkg::status_t status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= cnbs_pkg::CS_IDLE;
		else st_q <= st_d;
	end

	// issued_q marks a multi-cycle op in flight in this state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q <= 1'b0;
			steps_q <= '0;
			status_q <= cnbs_pkg::ST_CONVERGED;
		end else begin
			if (st_d != st_q) issued_q <= 1'b0;
			else if (cmd.start) issued_q <= 1'b1;
			if (go) begin
				steps_q <= '0;
				status_q <= zero_lig ? cnbs_pkg::ST_ZERO_LIGAND : cnbs_pkg::ST_ITER_LIMIT;
			end else if (st_q == cnbs_pkg::CS_Q && !issued_q && stat.fd_zero)
				status_q <= cnbs_pkg::ST_ZERO_DERIV;
			else if (st_q == cnbs_pkg::CS_CHK) begin
				if (stat.stop) status_q <= cnbs_pkg::ST_CONVERGED;
				else steps_q <= steps_q + SW'(1);
			end
		end
	end

	function automatic cnbs_pkg::dp_cmd_t mk(input cnbs_pkg::alu_op_t op,
		input logic [3:0] sa, input logic [3:0] sb, input logic [3:0] d, input logic ng);
		cnbs_pkg::dp_cmd_t c;
		c.start = 1'b1; c.op = op; c.src_a = sa; c.src_b = sb; c.dst = d; c.neg_b = ng;
		return c;
	endfunction

	always_comb begin
		cnbs_pkg::dp_cmd_t c;
		cnbs_pkg::ctl_state_t nx;
		c = '0;
		nx = st_q;
		case (st_q)
			cnbs_pkg::CS_IDLE: if (go) nx = zero_lig ? cnbs_pkg::CS_DONE : cnbs_pkg::CS_AR2;
			cnbs_pkg::CS_AR2: begin c = mk(cnbs_pkg::OP_MUL, cnbs_pkg::R_AB, cnbs_pkg::R_R2, cnbs_pkg::R_AR2, 1'b0); nx = cnbs_pkg::CS_R3X2; end
			cnbs_pkg::CS_R3X2: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_R3, cnbs_pkg::R_R3, cnbs_pkg::R_TMP, 1'b0); nx = cnbs_pkg::CS_R3M1; end
			cnbs_pkg::CS_R3M1: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_TMP, cnbs_pkg::R_ONE, cnbs_pkg::R_TMP, 1'b1); nx = cnbs_pkg::CS_NUM0; end
			cnbs_pkg::CS_NUM0: begin c = mk(cnbs_pkg::OP_MUL, cnbs_pkg::R_AR2, cnbs_pkg::R_TMP, cnbs_pkg::R_CB, 1'b0); nx = cnbs_pkg::CS_T2X2; end
			cnbs_pkg::CS_T2X2: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_T2, cnbs_pkg::R_T2, cnbs_pkg::R_TMP, 1'b0); nx = cnbs_pkg::CS_NUM1; end
			cnbs_pkg::CS_NUM1: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_CB, cnbs_pkg::R_TMP, cnbs_pkg::R_CB, 1'b1); nx = cnbs_pkg::CS_NUM2; end
			cnbs_pkg::CS_NUM2: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_CB, cnbs_pkg::R_T1, cnbs_pkg::R_CB, 1'b1); nx = cnbs_pkg::CS_NUM3; end
			cnbs_pkg::CS_NUM3: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_CB, cnbs_pkg::R_I1, cnbs_pkg::R_CB, 1'b1); nx = cnbs_pkg::CS_CB; end
			cnbs_pkg::CS_CB: begin c = mk(cnbs_pkg::OP_DIV, cnbs_pkg::R_CB, cnbs_pkg::R_T2, cnbs_pkg::R_CB, 1'b0); nx = cnbs_pkg::CS_C0; end
			cnbs_pkg::CS_C0: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_AR2, cnbs_pkg::R_I1, cnbs_pkg::R_CC, 1'b0); nx = cnbs_pkg::CS_C1; end
			cnbs_pkg::CS_C1: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_CC, cnbs_pkg::R_T2, cnbs_pkg::R_CC, 1'b0); nx = cnbs_pkg::CS_C2; end
			cnbs_pkg::CS_C2: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_T1, cnbs_pkg::R_T1, cnbs_pkg::R_TMP, 1'b0); nx = cnbs_pkg::CS_C3; end
			cnbs_pkg::CS_C3: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_CC, cnbs_pkg::R_TMP, cnbs_pkg::R_CC, 1'b0); nx = cnbs_pkg::CS_CC; end
			cnbs_pkg::CS_CC: begin c = mk(cnbs_pkg::OP_DIV, cnbs_pkg::R_CC, cnbs_pkg::R_T2, cnbs_pkg::R_CC, 1'b0); nx = cnbs_pkg::CS_CD; end
			cnbs_pkg::CS_CD: begin c = mk(cnbs_pkg::OP_DIV, cnbs_pkg::R_T1, cnbs_pkg::R_T2, cnbs_pkg::R_CD, 1'b0); nx = cnbs_pkg::CS_F0; end
			// R_CD holds +T1/T2; d is applied by subtraction below
			cnbs_pkg::CS_F0: begin
				if (steps_q == SW'(MAX_ITERATIONS)) nx = cnbs_pkg::CS_BOND;
				else begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_X, cnbs_pkg::R_CB, cnbs_pkg::R_F, 1'b0); nx = cnbs_pkg::CS_F1; end
			end
			cnbs_pkg::CS_F1: begin c = mk(cnbs_pkg::OP_MUL, cnbs_pkg::R_F, cnbs_pkg::R_X, cnbs_pkg::R_F, 1'b0); nx = cnbs_pkg::CS_F2; end
			cnbs_pkg::CS_F2: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_F, cnbs_pkg::R_CC, cnbs_pkg::R_F, 1'b0); nx = cnbs_pkg::CS_F3; end
			cnbs_pkg::CS_F3: begin c = mk(cnbs_pkg::OP_MUL, cnbs_pkg::R_F, cnbs_pkg::R_X, cnbs_pkg::R_F, 1'b0); nx = cnbs_pkg::CS_F4; end
			cnbs_pkg::CS_F4: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_F, cnbs_pkg::R_CD, cnbs_pkg::R_F, 1'b1); nx = cnbs_pkg::CS_D0; end
			cnbs_pkg::CS_D0: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_X, cnbs_pkg::R_X, cnbs_pkg::R_FD, 1'b0); nx = cnbs_pkg::CS_D1; end
			cnbs_pkg::CS_D1: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_FD, cnbs_pkg::R_X, cnbs_pkg::R_FD, 1'b0); nx = cnbs_pkg::CS_D2; end
			cnbs_pkg::CS_D2: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_CB, cnbs_pkg::R_CB, cnbs_pkg::R_TMP, 1'b0); nx = cnbs_pkg::CS_D3; end
			cnbs_pkg::CS_D3: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_FD, cnbs_pkg::R_TMP, cnbs_pkg::R_FD, 1'b0); nx = cnbs_pkg::CS_D4; end
			cnbs_pkg::CS_D4: begin
				if (!issued_q) c = mk(cnbs_pkg::OP_MUL, cnbs_pkg::R_FD, cnbs_pkg::R_X, cnbs_pkg::R_FD, 1'b0);
				else if (!stat.busy) begin
					c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_FD, cnbs_pkg::R_CC, cnbs_pkg::R_FD, 1'b0);
					nx = cnbs_pkg::CS_Q;
				end
			end
			cnbs_pkg::CS_Q: begin
				if (!issued_q) begin
					if (stat.fd_zero) nx = cnbs_pkg::CS_BOND;
					else c = mk(cnbs_pkg::OP_DIV, cnbs_pkg::R_F, cnbs_pkg::R_FD, cnbs_pkg::R_F, 1'b0);
				end else if (!stat.busy) nx = cnbs_pkg::CS_XN;
			end
			cnbs_pkg::CS_XN: begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_X, cnbs_pkg::R_F, cnbs_pkg::R_F, 1'b1); nx = cnbs_pkg::CS_CHK; end
			cnbs_pkg::CS_CHK: begin
				if (stat.stop) nx = cnbs_pkg::CS_BOND;
				else begin c = mk(cnbs_pkg::OP_ADD, cnbs_pkg::R_F, cnbs_pkg::R_ZERO, cnbs_pkg::R_X, 1'b0); nx = cnbs_pkg::CS_F0; end
			end
			cnbs_pkg::CS_BOND: begin
				if (!issued_q) c = mk(cnbs_pkg::OP_MUL, cnbs_pkg::R_T2, cnbs_pkg::R_X, cnbs_pkg::R_TMP, 1'b0);
				else if (!stat.busy) nx = cnbs_pkg::CS_DONE;
			end
			cnbs_pkg::CS_DONE: nx = cnbs_pkg::CS_IDLE;
			default: nx = cnbs_pkg::CS_IDLE;
		endcase
		// multiply/divide states wait on the unit before moving on
		if ((c.op == cnbs_pkg::OP_MUL || c.op == cnbs_pkg::OP_DIV) &&
				st_q != cnbs_pkg::CS_D4 && st_q != cnbs_pkg::CS_Q && st_q != cnbs_pkg::CS_BOND) begin
			if (issued_q) begin
				c.start = 1'b0;
				if (stat.busy) nx = st_q;
			end else nx = st_q;
		end
		if (stat.busy && (st_q == cnbs_pkg::CS_D4 || st_q == cnbs_pkg::CS_Q
				|| st_q == cnbs_pkg::CS_BOND)) c.start = 1'b0;
		cmd = c;
		st_d = nx;
	end

	assign load_in = go;
	assign busy = (st_q != cnbs_pkg::CS_IDLE);
	assign done = (st_q == cnbs_pkg::CS_DONE);
	assign steps = 5'(steps_q);
	assign status = status_q;

	ast_step_cap: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= SW'(MAX_ITERATIONS)) else $error("step count overrun");
	ast_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> st_q == cnbs_pkg::CS_IDLE) else $error("done not followed by idle");
	ast_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> st_q == cnbs_pkg::CS_IDLE) else $error("start while busy");
endmodule

>>> rtl/core/cubic_newton_bond_solver.sv
// Cubic Newton bond solver: one item at a time, bit-serial multiply and divide.
// Sequence: setup (multiplies, divides and adds), then up to MAX_ITERATIONS Newton steps
// (each three multiplies, one divide, nine add or test states), then the bond multiply;
// a zero ligand word skips setup and the Newton steps and goes straight to the result.
// A new item is taken only once the previous one is done and the solver is idle again.
// Reset (arst_n low) clears the configuration and controller registers and returns to
// idle; results are a one-cycle strobe the receiver cannot stall.
`timescale 1ns / 1ps
module cubic_newton_bond_solver #(
	parameter int MAX_ITERATIONS = cnbs_pkg::MaxIterations,
	parameter int FRACTION_BITS = cnbs_pkg::FractionBits
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cnbs_pkg::in_word_t in_word,
	output logic result_valid,
	output cnbs_pkg::out_word_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	logic [31:0] t1_q, i1_q, r2_q, r3_q;
	cnbs_pkg::dp_cmd_t cmd;
	cnbs_pkg::dp_stat_t stat;
	logic load_in, done, go, ctl_busy;
	logic [4:0] steps;
	cnbs_pkg::status_t status;
	logic [31:0] bond;

	assign cfg_ready = 1'b1;
	assign go = start && !busy;
	assign busy = ctl_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q <= '0; i1_q <= '0; r2_q <= '0; r3_q <= '0;
		end else if (cfg_valid) begin
			case (cnbs_pkg::reg_idx_t'(cfg_index))
				cnbs_pkg::REG_RECEPTOR: t1_q <= cfg_data;
				cnbs_pkg::REG_INV_RATE_ONE: i1_q <= cfg_data;
				cnbs_pkg::REG_RATE_TWO: r2_q <= cfg_data;
				cnbs_pkg::REG_RATE_THREE: r3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cnbs_control #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctl (
		.clk, .arst_n, .go, .zero_lig(in_word.ligand_level == 32'd0), .stat, .cmd,
		.load_in, .busy(ctl_busy), .done, .steps, .status);

	cnbs_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk, .arst_n, .in_word, .load_in, .t1(t1_q), .i1(i1_q), .r2(r2_q), .r3(r3_q),
		.cmd, .stat, .bond);

	assign result_valid = done;
	assign result.bond_level = (status == cnbs_pkg::ST_ZERO_LIGAND) ? 32'd0 : bond;
	assign result.iterations_used = steps;
	assign result.solve_status = status;

	ast_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double result");
	ast_busy_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside an item");
	ast_go: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy) else $error("item not taken");
endmodule

>>> dv/tb.sv
// Self-checking testbench for cubic_newton_bond_solver: drives ligand/antibody words,
// predicts each result with its own fixed-point Newton solver, and checks every strobe.
// Depends on cnbs_pkg and the solver RTL.
`timescale 1ns / 1ps
module tb;
	import cnbs_pkg::*;

	localparam longint FxMax = 64'd549755813887;  // 2^39 - 1
	localparam longint FxUnit = 64'd1 << FractionBits;
	localparam longint TolScale = 100000;
	localparam int CycleLimit = 10000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t in_word = '0;
	logic result_valid;
	out_word_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	in_word_t pending_words[$];
	out_word_t bond_expect[$];
	logic [31:0] binding_regs[4] = '{default: '0};
	int idle_pct = 0;
	int errors = 0;
	int cycles = 0;

	cubic_newton_bond_solver DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clip(longint v);
		if (v > FxMax) return FxMax;
		if (v < -FxMax) return -FxMax;
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint unsigned umul(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = ({64'b0, a} * {64'b0, b}) >> FractionBits;
		if (p > FxMax) return FxMax;
		return p[63:0];
	endfunction

	function automatic longint smul(longint a, longint b);
		longint m;
		m = umul(mag(a), mag(b));
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint sdiv(longint a, longint b);
		longint unsigned q;
		longint m;
		q = (mag(a) << FractionBits) / mag(b);
		m = (q > FxMax) ? FxMax : q;
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic out_word_t solve_bond(in_word_t w);
		out_word_t r;
		longint t2, ab, t1, i1, r2, r3, ar2, num, cb, cc, cd, x, f, fd, xn, delta;
		longint unsigned bond;
		int steps;
		status_t st;
		t2 = w.ligand_level;
		ab = w.antibody_level;
		t1 = binding_regs[REG_RECEPTOR];
		i1 = binding_regs[REG_INV_RATE_ONE];
		r2 = binding_regs[REG_RATE_TWO];
		r3 = binding_regs[REG_RATE_THREE];
		if (t2 == 0) begin
			r.bond_level = '0;
			r.iterations_used = '0;
			r.solve_status = ST_ZERO_LIGAND;
			return r;
		end
		ar2 = smul(ab, r2);
		num = smul(ar2, clip(clip(r3 + r3) - FxUnit));
		num = clip(num - clip(t2 + t2));
		num = clip(num - t1);
		num = clip(num - i1);
		cb = sdiv(num, t2);
		cc = sdiv(clip(clip(clip(ar2 + i1) + t2) + clip(t1 + t1)), t2);
		cd = -sdiv(t1, t2);
		x = 0;
		steps = 0;
		st = ST_ITER_LIMIT;
		while (steps < MaxIterations) begin
			f = smul(clip(x + cb), x);
			f = smul(clip(f + cc), x);
			f = clip(f + cd);
			fd = clip(clip(clip(x + x) + x) + clip(cb + cb));
			fd = clip(smul(fd, x) + cc);
			if (fd == 0) begin
				st = ST_ZERO_DERIV;
				break;
			end
			xn = clip(x - sdiv(f, fd));
			delta = xn - x;
			// stop on a negative estimate or a relative change within tolerance
			if (xn < 0 || mag(delta) * TolScale <= xn) begin
				st = ST_CONVERGED;
				break;
			end
			x = xn;
			steps++;
		end
		if (x <= 0) bond = 0;
		else begin
			bond = umul(t2, x);
			if (bond > 64'hFFFF_FFFF) bond = 64'hFFFF_FFFF;
		end
		r.bond_level = bond[31:0];
		r.iterations_used = steps[4:0];
		r.solve_status = st;
		return r;
	endfunction

	// launch the next word once the current one is taken; hold while busy
	always @(posedge clk) begin : drive
		bit launch;
		launch = 1'b0;
		if (arst_n && (!start || !busy) && pending_words.size() > 0 &&
				$urandom_range(99) >= idle_pct)
			launch = 1'b1;
		if (launch) begin
			in_word <= pending_words.pop_front();
			start <= 1'b1;
		end else if (!start || !busy) begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin : observe
		out_word_t e;
		if (result_valid) begin
			if (bond_expect.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				e = bond_expect.pop_front();
				if (result.bond_level !== e.bond_level) begin
					$display("%0t: bond_level expected %h actual %h", $time,
						e.bond_level, result.bond_level);
					errors++;
				end
				if (result.iterations_used !== e.iterations_used) begin
					$display("%0t: iterations_used expected %0d actual %0d", $time,
						e.iterations_used, result.iterations_used);
					errors++;
				end
				if (result.solve_status !== e.solve_status) begin
					$display("%0t: solve_status expected %0d actual %0d", $time,
						e.solve_status, result.solve_status);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) bond_expect.push_back(solve_bond(in_word));
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		binding_regs[idx] = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic load_regs(logic [31:0] t1, logic [31:0] i1, logic [31:0] r2,
			logic [31:0] r3);
		write_reg(REG_RECEPTOR, t1);
		write_reg(REG_INV_RATE_ONE, i1);
		write_reg(REG_RATE_TWO, r2);
		write_reg(REG_RATE_THREE, r3);
	endtask

	// wait until every queued word is taken and answered
	task automatic drain();
		do @(negedge clk);
		while (pending_words.size() != 0 || start || bond_expect.size() != 0);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_level();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0008_0000, 1);
			2: return $urandom_range(32'h00FF_0000, 32'h0001_0000);
			default: begin
				case ($urandom_range(3))
					0: return 32'h0;
					1: return 32'h1;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_reg();
		return ($urandom_range(1)) ? $urandom : $urandom_range(32'h0010_0000);
	endfunction

	task automatic push_word(logic [31:0] lig, logic [31:0] ab);
		in_word_t w;
		w.ligand_level = lig;
		w.antibody_level = ab;
		pending_words.push_back(w);
	endtask

	task automatic push_random(int n);
		repeat (n) push_word(pick_level(), pick_level());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// registers at reset: trivial cubic, zero ligand, extremes
		idle_pct = 0;
		push_word(32'h0, 32'h0);
		push_word(32'h0, 32'hFFFF_FFFF);
		push_word(32'h1, 32'h0);
		push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(32'h0001_0000, 32'h0001_0000);
		drain();
		load_regs(32'h0005_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
		push_word(32'h0, 32'h0002_0000);
		push_word(32'h1, 32'h1);
		push_word(32'hFFFF_FFFF, 32'h0);
		push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(32'h0003_0000, 32'h0);
		push_word(32'h0003_0000, 32'h0004_0000);
		push_word(32'h0000_4000, 32'h0010_0000);
		push_word(32'h0100_0000, 32'h0000_0100);
		drain();
		load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(32'h1, 32'hFFFF_FFFF);
		push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(32'h0001_0000, 32'h0);
		push_word(32'h0, 32'h1);
		push_random(40);
		drain();
		load_regs(32'h0005_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
		idle_pct = 0;
		push_random(90);
		drain();
		load_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg());
		idle_pct = 55;
		push_random(90);
		drain();
		load_regs(32'h0, 32'h0, 32'h0, 32'h0);
		idle_pct = 30;
		push_random(40);
		drain();
		load_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg());
		idle_pct = 30;
		push_random(90);
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/cnbs_pkg.sv
rtl/core/cnbs_datapath.sv
rtl/core/cnbs_control.sv
rtl/core/cubic_newton_bond_solver.sv
dv/tb.sv
